/* sv/integer_pixel_replication_upscaler_unit_macros.svh */
// Assertion macros shared by the upscaler modules.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef INTEGER_PIXEL_REPLICATION_UPSCALER_UNIT_MACROS_SVH
`define INTEGER_PIXEL_REPLICATION_UPSCALER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IPRU_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IPRU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/ipru_pkg.sv */
package ipru_pkg;

    localparam int CHAN_W   = 8;
    localparam int PIX_W    = 3 * CHAN_W;
    localparam int SCALE_W  = 7;
    localparam int SWIDTH_W = 11;
    localparam int PAD_W    = 2;
    localparam int REG_IDX_W = 1;

    localparam logic [SCALE_W-1:0] SCALE_MIN = 7'd1;
    localparam logic [SCALE_W-1:0] SCALE_MAX = 7'd100;

    // Item actions
    localparam logic ACT_PUSH    = 1'b0;
    localparam logic ACT_ADVANCE = 1'b1;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_SCALE = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_WIDTH = 1'd1;

    // Result status codes
    localparam logic STAT_OK     = 1'b0;
    localparam logic STAT_REJECT = 1'b1;

    // Per-item control passed from the sequencer to the output pipeline.
    typedef struct packed {
        logic               reject;
        logic               from_ram;
        logic               row_end;
        logic [PAD_W-1:0]   pad;
        logic [SCALE_W-1:0] rep_count;
    } item_ctl_t;

endpackage

/* sv/ipru_in_if.sv */
interface ipru_in_if;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [ipru_pkg::CHAN_W-1:0]   blue_in;
    logic [ipru_pkg::CHAN_W-1:0]   green_in;
    logic [ipru_pkg::CHAN_W-1:0]   red_in;

    modport source (output valid, action, blue_in, green_in, red_in, input ready);
    modport sink   (input valid, action, blue_in, green_in, red_in, output ready);
endinterface

/* sv/ipru_out_if.sv */
interface ipru_out_if;
    logic                          valid;
    logic                          ready;
    logic [ipru_pkg::CHAN_W-1:0]   blue_out;
    logic [ipru_pkg::CHAN_W-1:0]   green_out;
    logic [ipru_pkg::CHAN_W-1:0]   red_out;
    logic [ipru_pkg::SCALE_W-1:0]  repeat_res;
    logic                          row_end;
    logic [ipru_pkg::PAD_W-1:0]    pad_bytes;
    logic                          status;

    modport source (output valid, blue_out, green_out, red_out, repeat_res, row_end,
                    pad_bytes, status, input ready);
    modport sink   (input valid, blue_out, green_out, red_out, repeat_res, row_end,
                    pad_bytes, status, output ready);
endinterface

/* sv/ipru_ram.sv */
module ipru_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/ipru_ctrl.sv */
`include "integer_pixel_replication_upscaler_unit_macros.svh"

module ipru_ctrl #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            accept,
    input  logic                                            action,
    input  logic                                            wr_en,
    input  logic [ipru_pkg::REG_IDX_W-1:0]                  wr_index,
    input  logic [ipru_pkg::SWIDTH_W-1:0]                   wr_data,
    output ipru_pkg::item_ctl_t                             ctl,
    output logic                                            mem_we,
    output logic                                            mem_re,
    output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] mem_addr
);

    localparam int ADDR_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int LAST_MAX = MAX_WIDTH - 1;

    logic [ipru_pkg::SCALE_W-1:0] scale_reg, scale_next;
    logic [ADDR_W-1:0]            last_reg, last_next;
    logic [ADDR_W-1:0]            fill_reg, fill_next;
    logic [ADDR_W-1:0]            replay_reg, replay_next;
    logic [ipru_pkg::SCALE_W-1:0] left_reg, left_next;
    logic                         replaying_reg, replaying_next;

    logic [31:0]                  wdata32;
    logic [ipru_pkg::SCALE_W-1:0] sdata;
    logic [ipru_pkg::SCALE_W-1:0] left_dec;
    logic [ADDR_W:0]              wcount;
    logic [3:0]                   pad_prod;
    logic [ADDR_W-1:0]            col;
    logic                         row_end;
    logic                         reject;
    logic                         take;

    // Configuration is stored already clamped: scale in 1..100 and the width as
    // the index of the last column.
    always_comb
    begin
        wdata32    = 32'(wr_data);
        sdata      = wr_data[ipru_pkg::SCALE_W-1:0];
        scale_next = scale_reg;
        last_next  = last_reg;
        if (wr_en)
        begin
            case (wr_index)
                ipru_pkg::REG_SCALE:
                begin
                    if (sdata == '0)
                        scale_next = ipru_pkg::SCALE_MIN;
                    else if (sdata > ipru_pkg::SCALE_MAX)
                        scale_next = ipru_pkg::SCALE_MAX;
                    else
                        scale_next = sdata;
                end
                ipru_pkg::REG_WIDTH:
                begin
                    if (wdata32 == 32'd0)
                        last_next = '0;
                    else if (wdata32 > 32'(MAX_WIDTH))
                        last_next = ADDR_W'(LAST_MAX);
                    else
                        last_next = ADDR_W'(wdata32 - 32'd1);
                end
                default:
                begin
                end
            endcase
        end
    end

    // A row of width*scale*3 bytes needs (width*scale) mod 4 pad bytes.
    always_comb
    begin
        wcount   = {1'b0, last_reg} + {{ADDR_W{1'b0}}, 1'b1};
        pad_prod = {2'b00, wcount[1:0]} * {2'b00, scale_reg[1:0]};
        reject   = ((action == ipru_pkg::ACT_PUSH) == replaying_reg);
        col      = (action == ipru_pkg::ACT_PUSH) ? fill_reg : replay_reg;
        row_end  = (col >= last_reg);
        take     = accept && !reject;
    end

    always_comb
    begin
        ctl.reject    = reject;
        ctl.from_ram  = (action == ipru_pkg::ACT_ADVANCE);
        ctl.row_end   = row_end;
        ctl.pad       = row_end ? pad_prod[1:0] : '0;
        ctl.rep_count = scale_reg;
        mem_we        = take && (action == ipru_pkg::ACT_PUSH);
        mem_re        = take && (action == ipru_pkg::ACT_ADVANCE);
        mem_addr      = col;
    end

    always_comb
    begin
        fill_next      = fill_reg;
        replay_next    = replay_reg;
        left_next      = left_reg;
        replaying_next = replaying_reg;
        left_dec       = (left_reg != '0) ? left_reg - 7'd1 : left_reg;
        if (take)
        begin
            if (action == ipru_pkg::ACT_PUSH)
            begin
                if (row_end)
                begin
                    fill_next      = '0;
                    replay_next    = '0;
                    left_next      = scale_reg - 7'd1;
                    replaying_next = (scale_reg != ipru_pkg::SCALE_MIN);
                end
                else
                begin
                    fill_next = col + ADDR_W'(1);
                end
            end
            else
            begin
                if (row_end)
                begin
                    replay_next = '0;
                    left_next   = left_dec;
                    if (left_dec == '0)
                        replaying_next = 1'b0;
                end
                else
                begin
                    replay_next = col + ADDR_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg     <= ipru_pkg::SCALE_MIN;
            last_reg      <= '0;
            fill_reg      <= '0;
            replay_reg    <= '0;
            left_reg      <= '0;
            replaying_reg <= 1'b0;
        end
        else
        begin
            scale_reg     <= scale_next;
            last_reg      <= last_next;
            fill_reg      <= fill_next;
            replay_reg    <= replay_next;
            left_reg      <= left_next;
            replaying_reg <= replaying_next;
        end
    end

    `IPRU_ASSERT_IMPL(a_replay_has_passes, replaying_reg, left_reg != '0, "replay mode with no passes left")
    `IPRU_ASSERT_NEXT(a_reject_keeps_state, accept && reject && !wr_en, $stable(fill_reg) && $stable(replay_reg) && $stable(replaying_reg), "rejected word changed state")
    `IPRU_ASSERT_NEXT(a_unit_scale_no_replay, take && !action && row_end && scale_reg == ipru_pkg::SCALE_MIN, !replaying_reg, "unit scale entered replay")

endmodule

/* sv/integer_pixel_replication_upscaler_unit.sv */
// A result word passes through the first stage and then the output register after its input word is accepted.
// Throughput: one input word and one result word per clock, sustained while results.ready stays high.
// Each word makes a single access to the line memory (a write for a push, a read for an
// advance); the write and read ports share one address.
// Reset (rst_n, asynchronous, active low) clears the mode, the columns, the pass count
// and the pipeline, and sets scale and width to 1; the line memory is not cleared.
`include "integer_pixel_replication_upscaler_unit_macros.svh"

module integer_pixel_replication_upscaler_unit #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    ipru_in_if.sink                             pixels,
    ipru_out_if.source                          results,
    input  logic                                wr_en,
    input  logic [ipru_pkg::REG_IDX_W-1:0]      wr_index,
    input  logic [ipru_pkg::SWIDTH_W-1:0]       wr_data
);

    localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    // The pipeline has two registered stages. The first holds the accepted word's
    // control and, for a push, its pixel; for an advance the pixel comes from the line
    // memory, whose read data lands in that same cycle. The second is the output
    // register, so a new word is taken while a finished result waits to be collected.
    //
    // A push writes the memory and an advance reads it, never both in one cycle. The
    // first advance after a row's last push reads an entry written at an earlier edge,
    // so no forwarding path is needed.

    ipru_pkg::item_ctl_t            ctl;
    ipru_pkg::item_ctl_t            s1_ctl_reg;
    logic [ipru_pkg::PIX_W-1:0]     s1_pix_reg;
    logic                           s1_valid_reg, s1_valid_next;
    logic                           s1_adv;
    logic                           accept;

    logic                           ram_we;
    logic                           ram_re;
    logic [ADDR_W-1:0]              ram_addr;
    logic [ipru_pkg::PIX_W-1:0]     ram_rdata;
    logic [ipru_pkg::PIX_W-1:0]     in_pix;
    logic [ipru_pkg::PIX_W-1:0]     s1_pix;

    logic                           out_valid_reg, out_valid_next;
    logic [ipru_pkg::PIX_W-1:0]     out_pix_reg;
    logic [ipru_pkg::SCALE_W-1:0]   out_rep_reg;
    logic                           out_end_reg;
    logic [ipru_pkg::PAD_W-1:0]     out_pad_reg;
    logic                           out_stat_reg;

    // The first stage moves on whenever the output register is empty or being drained.
    assign s1_adv       = !out_valid_reg || results.ready;
    assign pixels.ready = !s1_valid_reg || s1_adv;
    assign accept       = pixels.valid && pixels.ready;
    assign in_pix       = {pixels.red_in, pixels.green_in, pixels.blue_in};

    ipru_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .action   (pixels.action),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .ctl      (ctl),
        .mem_we   (ram_we),
        .mem_re   (ram_re),
        .mem_addr (ram_addr)
    );

    // The read data register only changes on an accepted advance, so it stays put
    // while the first stage is stalled.
    ipru_ram #(
        .WIDTH (ipru_pkg::PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (in_pix),
        .re    (ram_re),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        s1_valid_next  = pixels.ready ? pixels.valid : s1_valid_reg;
        out_valid_next = s1_adv ? s1_valid_reg : out_valid_reg;
        s1_pix         = s1_ctl_reg.from_ram ? ram_rdata : s1_pix_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers; a rejected word carries zeros in every field but status.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ctl_reg <= ctl;
            s1_pix_reg <= in_pix;
        end
        if (s1_valid_reg && s1_adv)
        begin
            if (s1_ctl_reg.reject)
            begin
                out_pix_reg  <= '0;
                out_rep_reg  <= '0;
                out_end_reg  <= 1'b0;
                out_pad_reg  <= '0;
                out_stat_reg <= ipru_pkg::STAT_REJECT;
            end
            else
            begin
                out_pix_reg  <= s1_pix;
                out_rep_reg  <= s1_ctl_reg.rep_count;
                out_end_reg  <= s1_ctl_reg.row_end;
                out_pad_reg  <= s1_ctl_reg.pad;
                out_stat_reg <= ipru_pkg::STAT_OK;
            end
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.blue_out   = out_pix_reg[ipru_pkg::CHAN_W-1:0];
    assign results.green_out  = out_pix_reg[2*ipru_pkg::CHAN_W-1:ipru_pkg::CHAN_W];
    assign results.red_out    = out_pix_reg[3*ipru_pkg::CHAN_W-1:2*ipru_pkg::CHAN_W];
    assign results.repeat_res = out_rep_reg;
    assign results.row_end    = out_end_reg;
    assign results.pad_bytes  = out_pad_reg;
    assign results.status     = out_stat_reg;

    `IPRU_ASSERT_IMPL(a_stall_no_read, s1_valid_reg && !s1_adv, !ram_re, "memory read while first stage stalled")
    `IPRU_ASSERT_IMPL(a_single_access, ram_we, !ram_re, "memory read and write in one cycle")
    `IPRU_ASSERT_NEXT(a_stage_moves, s1_valid_reg && s1_adv, out_valid_reg, "first stage word lost on its way out")

endmodule
